FILE: design/circular_ready_queue_with_remove_macros.svh
// Assertion macros for the circular ready queue.
// Included by the top level; depends on nothing else.
`ifndef CIRCULAR_READY_QUEUE_WITH_REMOVE_MACROS_SVH
`define CIRCULAR_READY_QUEUE_WITH_REMOVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("circular ready queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("circular ready queue check failed");

`endif

FILE: design/crq_pkg.sv
// Shared types and constants of the circular ready queue.
// Used by the controller and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package crq_pkg;

	localparam int FUNC_W  = 2;
	localparam int PID_W   = 8;
	localparam int COUNT_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_PUSH_FULL = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [PID_W-1:0]   popped_id;
		status_t            status;
		logic [COUNT_W-1:0] entry_count;
		logic               is_empty;
		logic               is_full;
	} result_t;

endpackage

`default_nettype wire

FILE: design/circular_ready_queue_with_remove.sv
// Top level of the circular ready queue with remove by id.
// Depends on crq_pkg, crq_slot_ram, crq_ctrl and the assertion macro header.
//
//   channel  valid      stall      word
//   request  req_valid  req_stall  func, process_id
//   result   rsp_valid  rsp_stall  popped_id, status, entry_count, is_empty, is_full
//
// A request is taken only while the sequencer is idle, one at a time.
// Push and clear go straight to the result, pop first reads the head slot, and
// remove scans the entries in order and then shifts every later slot down by one.
// The remove time is set by the single read port of the slot memory.
// Reset clears head and tail; slot contents are undefined until written.
// The result register lets the sequencer take the next request while a result
// is stalled; the sequencer waits only if a second result is ready first.
`timescale 1ns / 1ps
`default_nettype none

`include "circular_ready_queue_with_remove_macros.svh"

module circular_ready_queue_with_remove #(
	parameter int QUEUE_SLOTS = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [crq_pkg::FUNC_W-1:0]   func,
	input  wire logic [crq_pkg::PID_W-1:0]    process_id,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic [crq_pkg::PID_W-1:0]         popped_id,
	output logic [1:0]                        status,
	output logic [crq_pkg::COUNT_W-1:0]       entry_count,
	output logic                              is_empty,
	output logic                              is_full
);

	localparam int IDX_W = $clog2(QUEUE_SLOTS);

	logic               res_valid, res_take;
	crq_pkg::result_t   res, rsp_q;
	logic               rsp_valid_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [ID_BITS-1:0] mem_wdata, mem_rdata;

	crq_slot_ram #(
		.DEPTH  (QUEUE_SLOTS),
		.WIDTH  (ID_BITS),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	crq_ctrl #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.ID_BITS     (ID_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.process_id (process_id),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign popped_id   = rsp_q.popped_id;
	assign status      = rsp_q.status;
	assign entry_count = rsp_q.entry_count;
	assign is_empty    = rsp_q.is_empty;
	assign is_full     = rsp_q.is_full;

	`CRQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && !req_stall, req_stall)
	`CRQ_ASSERT_IMP(a_pop_empty, clk, arst_n, rsp_valid && status == crq_pkg::STAT_POP_EMPTY, is_empty && popped_id == '0)
	`CRQ_ASSERT_IMP(a_push_full, clk, arst_n, rsp_valid && status == crq_pkg::STAT_PUSH_FULL, is_full)
	`CRQ_ASSERT_IMP(a_flags_apart, clk, arst_n, rsp_valid, !(is_empty && is_full))

endmodule

`default_nettype wire

FILE: design/crq_slot_ram.sv
// Slot memory of the circular ready queue: one write port, one read port,
// registered read data. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module crq_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: design/crq_ctrl.sv
// Sequencer of the circular ready queue: head and tail indices, request
// decoding, the remove scan and shift over the slot memory. Uses crq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crq_ctrl #(
	parameter int QUEUE_SLOTS = 16,
	parameter int ID_BITS     = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic [crq_pkg::FUNC_W-1:0]         func,
	input  wire logic [crq_pkg::PID_W-1:0]          process_id,
	output logic                                    res_valid,
	input  wire logic                               res_take,
	output crq_pkg::result_t                        res,
	output logic                                    mem_we,
	output logic [$clog2(QUEUE_SLOTS)-1:0]          mem_waddr,
	output logic [ID_BITS-1:0]                      mem_wdata,
	output logic [$clog2(QUEUE_SLOTS)-1:0]          mem_raddr,
	input  wire logic [ID_BITS-1:0]                 mem_rdata
);

	localparam int IDX_W = $clog2(QUEUE_SLOTS);
	localparam int CNT_W = IDX_W + 1;

	function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(QUEUE_SLOTS - 1) : i - IDX_W'(1);
	endfunction

	crq_pkg::state_t          state_q, state_d;
	logic [IDX_W-1:0]         head_q, tail_q, ptr_q;
	logic [ID_BITS-1:0]       id_q;
	logic [crq_pkg::PID_W-1:0] popped_q;
	crq_pkg::status_t         status_q;

	crq_pkg::func_t           req_func;
	logic                     accept;
	logic                     ring_empty, ring_full;
	logic                     match, last;
	logic [IDX_W-1:0]         ptr_nxt;
	logic [CNT_W-1:0]         diff, count;

	assign req_func   = crq_pkg::func_t'(func);
	assign accept     = req_valid && (state_q == crq_pkg::ST_IDLE);
	assign ring_empty = (head_q == tail_q);
	assign ring_full  = (step_fwd(tail_q) == head_q);
	assign match      = (mem_rdata == id_q);
	assign ptr_nxt    = step_fwd(ptr_q);
	assign last       = (ptr_nxt == tail_q);

	assign diff  = {1'b0, tail_q} - {1'b0, head_q};
	assign count = diff[CNT_W-1] ? diff + CNT_W'(QUEUE_SLOTS) : diff;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crq_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req_func)
						crq_pkg::FUNC_POP:
							state_d = ring_empty ? crq_pkg::ST_DONE : crq_pkg::ST_POP;
						crq_pkg::FUNC_REMOVE:
							state_d = ring_empty ? crq_pkg::ST_DONE : crq_pkg::ST_SCAN;
						default:
							state_d = crq_pkg::ST_DONE;
					endcase
				end
			end
			crq_pkg::ST_POP: begin
				state_d = crq_pkg::ST_DONE;
			end
			crq_pkg::ST_SCAN: begin
				if (match) begin
					state_d = crq_pkg::ST_SHIFT;
				end else if (last) begin
					state_d = crq_pkg::ST_DONE;
				end
			end
			crq_pkg::ST_SHIFT: begin
				if (last) begin
					state_d = crq_pkg::ST_DONE;
				end
			end
			crq_pkg::ST_DONE: begin
				if (res_take) begin
					state_d = crq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crq_pkg::ST_IDLE;
			end
		endcase
	end

	// Shift writes trail the read address by two slots and a shift is shorter
	// than the ring, so a read never meets a pending write to the same slot.
	always_comb begin
		req_stall = (state_q != crq_pkg::ST_IDLE);
		res_valid = (state_q == crq_pkg::ST_DONE);
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = ID_BITS'(process_id);
		mem_raddr = head_q;
		unique case (state_q)
			crq_pkg::ST_IDLE: begin
				mem_we = req_valid && (req_func == crq_pkg::FUNC_PUSH) && !ring_full;
			end
			crq_pkg::ST_SCAN: begin
				mem_raddr = ptr_nxt;
			end
			crq_pkg::ST_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = mem_rdata;
				mem_raddr = step_fwd(ptr_nxt);
			end
			default: begin
			end
		endcase
		res.popped_id   = popped_q;
		res.status      = status_q;
		res.entry_count = crq_pkg::COUNT_W'(count);
		res.is_empty    = ring_empty;
		res.is_full     = ring_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crq_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (req_func)
					crq_pkg::FUNC_PUSH: begin
						if (!ring_full) begin
							tail_q <= step_fwd(tail_q);
						end
					end
					crq_pkg::FUNC_CLEAR: begin
						head_q <= '0;
						tail_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (state_q == crq_pkg::ST_POP) begin
				head_q <= step_fwd(head_q);
			end else if (state_q == crq_pkg::ST_SHIFT && last) begin
				tail_q <= step_back(tail_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q     <= ID_BITS'(process_id);
			ptr_q    <= head_q;
			popped_q <= '0;
			status_q <= crq_pkg::STAT_OK;
			case (req_func)
				crq_pkg::FUNC_PUSH: begin
					if (ring_full) begin
						status_q <= crq_pkg::STAT_PUSH_FULL;
					end
				end
				crq_pkg::FUNC_POP: begin
					if (ring_empty) begin
						status_q <= crq_pkg::STAT_POP_EMPTY;
					end
				end
				crq_pkg::FUNC_REMOVE: begin
					if (ring_empty) begin
						status_q <= crq_pkg::STAT_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == crq_pkg::ST_POP) begin
			popped_q <= crq_pkg::PID_W'(mem_rdata);
		end else if (state_q == crq_pkg::ST_SCAN && !match) begin
			if (last) begin
				status_q <= crq_pkg::STAT_NOT_FOUND;
			end else begin
				ptr_q <= ptr_nxt;
			end
		end else if (state_q == crq_pkg::ST_SHIFT && !last) begin
			ptr_q <= ptr_nxt;
		end
	end

endmodule

`default_nettype wire
